// ===== src/prqs_pkg.sv =====
`default_nettype none

package prqs_pkg;

	// default number of task slots
	localparam int MAX_TASKS_DEF = 8;

	// fixed field widths
	localparam int PRIO_W   = 8;
	localparam int TASK_W   = 3;
	localparam int COUNT_W  = 4;
	localparam int STATUS_W = 2;

	typedef enum logic [1:0] {
		REQ_TICK   = 2'd0,
		REQ_RESUME = 2'd1,
		REQ_END    = 2'd2,
		REQ_CREATE = 2'd3
	} req_kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK   = 2'd0,
		STAT_ERR  = 2'd1,
		STAT_FULL = 2'd2
	} status_t;

	// one incoming request
	typedef struct packed {
		req_kind_t           req_type;
		logic [TASK_W-1:0]   task_id;
		logic [PRIO_W-1:0]   priority_req;
		logic                create_idle;
		logic                cur_ready;
	} req_t;

	// one scheduling result
	typedef struct packed {
		logic [TASK_W-1:0]   current_task;
		logic                current_valid;
		logic                running_idle;
		status_t             status;
		logic [COUNT_W-1:0]  queue_count;
	} res_t;

endpackage

`default_nettype wire

// ===== src/priority_ready_queue_scheduler_unit.sv =====
// A request is decoded and may then walk the ready queue: a sorted insert walks from
// the tail toward the head, and a removal walks from the head through the whole queue.
// The longest request is a tick that requeues (a sorted insert, then a removal).
// One request is handled at a time; the next request is taken once the sequencer is
// back in idle after its result is loaded, as the queue RAM is walked one entry at a time.
// Reset: arst_n asynchronously clears all control state; the priority and order
// RAMs are not cleared and need no clearing pass.
`default_nettype none

module priority_ready_queue_scheduler_unit #(
	parameter int MAX_TASKS = prqs_pkg::MAX_TASKS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	// [2:0] task_id, [10:3] priority_req, [11] create_idle, [12] cur_ready
	input  wire logic [15:0] s_tdata,
	// [1:0] req_type
	input  wire logic [1:0]  s_tuser,
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	// [2:0] current_task, [3] current_valid, [4] running_idle, [6:5] status,
	// [10:7] queue_count
	output      logic [15:0] m_tdata
);

	prqs_pkg::req_t req;
	prqs_pkg::res_t res;
	logic           seq_idle;
	logic           seq_done;
	logic           out_free;
	logic           m_tvalid_q;
	logic [15:0]    m_tdata_q;

	// unpack request
	assign req.req_type     = prqs_pkg::req_kind_t'(s_tuser);
	assign req.task_id      = s_tdata[2:0];
	assign req.priority_req = s_tdata[10:3];
	assign req.create_idle  = s_tdata[11];
	assign req.cur_ready    = s_tdata[12];

	assign s_tready = seq_idle;
	assign out_free = !m_tvalid_q || m_tready;

	prqs_seq #(.MAX_TASKS(MAX_TASKS)) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (s_tvalid && seq_idle),
		.req      (req),
		.out_free (out_free),
		.idle     (seq_idle),
		.done     (seq_done),
		.res      (res)
	);

	// output register: load a finished result, hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (seq_done && out_free) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= {5'd0, res.queue_count, res.status, res.running_idle,
				               res.current_valid, res.current_task};
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

// ===== src/prqs_ram.sv =====
`default_nettype none

module prqs_ram #(
	parameter int DEPTH = prqs_pkg::MAX_TASKS_DEF,
	parameter int WIDTH = prqs_pkg::PRIO_W
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== src/prqs_seq.sv =====
`default_nettype none

module prqs_seq #(
	parameter int MAX_TASKS = prqs_pkg::MAX_TASKS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire prqs_pkg::req_t req,
	input  wire logic           out_free,
	output      logic           idle,
	output      logic           done,
	output      prqs_pkg::res_t res
);

	localparam int SW = $clog2(MAX_TASKS);
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam int PW = prqs_pkg::PRIO_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_RES_RD,
		S_RES_INS,
		S_TK_HEAD,
		S_TK_HPRIO,
		S_TK_RPRIO,
		S_TK_CMP,
		S_INS_START,
		S_INS_LOOK,
		S_INS_ORD,
		S_INS_CMP,
		S_RM_LOOK,
		S_RM_CHK,
		S_PICK,
		S_DONE
	} state_t;

	state_t                state_q;
	prqs_pkg::req_t        req_q;
	prqs_pkg::status_t     status_q;
	logic [MAX_TASKS-1:0]  live_q;
	logic [MAX_TASKS-1:0]  queued_q;
	logic [CW-1:0]         len_q;
	logic [CW-1:0]         used_q;
	logic [SW-1:0]         run_slot_q;
	logic                  run_valid_q;
	logic [SW-1:0]         idle_slot_q;
	logic                  idle_valid_q;
	logic [CW-1:0]         idx_q;
	logic [SW-1:0]         ins_slot_q;
	logic [PW-1:0]         ins_prio_q;
	logic                  then_pop_q;
	logic                  walk_pop_q;
	logic                  found_q;
	logic [SW-1:0]         target_q;
	logic [SW-1:0]         rm_q;
	logic [SW-1:0]         entry_q;
	logic [PW-1:0]         head_prio_q;

	// memory ports
	logic                  prio_we;
	logic [SW-1:0]         prio_waddr;
	logic [PW-1:0]         prio_wdata;
	logic [SW-1:0]         prio_raddr;
	logic [PW-1:0]         prio_rdata;
	logic                  order_we;
	logic [SW-1:0]         order_waddr;
	logic [SW-1:0]         order_wdata;
	logic [SW-1:0]         order_raddr;
	logic [SW-1:0]         order_rdata;

	logic [SW-1:0]         tid_slot;
	logic                  tid_ok;
	logic                  resume_err;
	logic                  table_full;
	logic                  queue_full;
	logic [CW-1:0]         idx_dec;
	logic                  rm_match;
	logic                  run_is_idle;

	prqs_ram #(.DEPTH(MAX_TASKS), .WIDTH(PW)) u_prio_ram (
		.clk   (clk),
		.we    (prio_we),
		.waddr (prio_waddr),
		.wdata (prio_wdata),
		.raddr (prio_raddr),
		.rdata (prio_rdata)
	);

	prqs_ram #(.DEPTH(MAX_TASKS), .WIDTH(SW)) u_order_ram (
		.clk   (clk),
		.we    (order_we),
		.waddr (order_waddr),
		.wdata (order_wdata),
		.raddr (order_raddr),
		.rdata (order_rdata)
	);

	// request decode
	assign tid_slot    = SW'(req_q.task_id);
	assign tid_ok      = (32'(req_q.task_id) < MAX_TASKS);
	assign resume_err  = !tid_ok || !live_q[tid_slot] ||
	                     (idle_valid_q && idle_slot_q == tid_slot) ||
	                     (run_valid_q && run_slot_q == tid_slot) || queued_q[tid_slot];
	assign table_full  = (used_q >= CW'(MAX_TASKS));
	assign queue_full  = (len_q >= CW'(MAX_TASKS));
	assign idx_dec     = idx_q - CW'(1);
	assign rm_match    = walk_pop_q ? (idx_q == '0) : (order_rdata == target_q);
	assign run_is_idle = run_valid_q && idle_valid_q && (run_slot_q == idle_slot_q);

	// memory addressing per step
	always_comb begin
		prio_we     = 1'b0;
		prio_waddr  = used_q[SW-1:0];
		prio_wdata  = req_q.priority_req;
		prio_raddr  = '0;
		order_we    = 1'b0;
		order_waddr = idx_q[SW-1:0];
		order_wdata = ins_slot_q;
		order_raddr = '0;
		case (state_q)
			S_DISPATCH: begin
				prio_we = (req_q.req_type == prqs_pkg::REQ_CREATE) && !table_full;
			end
			S_RES_RD: begin
				prio_raddr = tid_slot;
			end
			S_TK_HPRIO: begin
				prio_raddr = order_rdata;
			end
			S_TK_RPRIO: begin
				prio_raddr = run_slot_q;
			end
			S_INS_LOOK: begin
				if (idx_q == '0) begin
					order_we = 1'b1;
				end else begin
					order_raddr = idx_dec[SW-1:0];
				end
			end
			S_INS_ORD: begin
				prio_raddr = order_rdata;
			end
			S_INS_CMP: begin
				order_we = 1'b1;
				if (prio_rdata > ins_prio_q) begin
					order_wdata = entry_q;
				end
			end
			S_RM_LOOK: begin
				if (idx_q != len_q) begin
					order_raddr = idx_q[SW-1:0];
				end
			end
			S_RM_CHK: begin
				// shift entries behind the removed one forward
				order_we    = found_q;
				order_waddr = idx_dec[SW-1:0];
				order_wdata = order_rdata;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			req_q        <= '0;
			status_q     <= prqs_pkg::STAT_OK;
			live_q       <= '0;
			queued_q     <= '0;
			len_q        <= '0;
			used_q       <= '0;
			run_slot_q   <= '0;
			run_valid_q  <= 1'b0;
			idle_slot_q  <= '0;
			idle_valid_q <= 1'b0;
			idx_q        <= '0;
			ins_slot_q   <= '0;
			ins_prio_q   <= '0;
			then_pop_q   <= 1'b0;
			walk_pop_q   <= 1'b0;
			found_q      <= 1'b0;
			target_q     <= '0;
			rm_q         <= '0;
			entry_q      <= '0;
			head_prio_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q    <= req;
						status_q <= prqs_pkg::STAT_OK;
						state_q  <= S_DISPATCH;
					end
				end

				S_DISPATCH: begin
					case (req_q.req_type)
						prqs_pkg::REQ_CREATE: begin
							if (table_full) begin
								status_q <= prqs_pkg::STAT_FULL;
								state_q  <= S_DONE;
							end else begin
								used_q                   <= used_q + CW'(1);
								live_q[used_q[SW-1:0]]   <= 1'b1;
								if (req_q.create_idle) begin
									idle_slot_q  <= used_q[SW-1:0];
									idle_valid_q <= 1'b1;
								end
								if (!run_valid_q) begin
									run_slot_q  <= used_q[SW-1:0];
									run_valid_q <= 1'b1;
									state_q     <= S_DONE;
								end else if (!req_q.create_idle) begin
									ins_slot_q <= used_q[SW-1:0];
									ins_prio_q <= req_q.priority_req;
									then_pop_q <= 1'b0;
									state_q    <= S_INS_START;
								end else begin
									state_q <= S_DONE;
								end
							end
						end
						prqs_pkg::REQ_RESUME: begin
							if (resume_err) begin
								status_q <= prqs_pkg::STAT_ERR;
								state_q  <= S_DONE;
							end else begin
								ins_slot_q <= tid_slot;
								then_pop_q <= 1'b0;
								state_q    <= S_RES_RD;
							end
						end
						prqs_pkg::REQ_END: begin
							if (!run_valid_q) begin
								status_q <= prqs_pkg::STAT_ERR;
								state_q  <= S_DONE;
							end else begin
								live_q[run_slot_q] <= 1'b0;
								if (idle_valid_q && idle_slot_q == run_slot_q) begin
									idle_valid_q <= 1'b0;
								end
								if (queued_q[run_slot_q]) begin
									idx_q      <= '0;
									found_q    <= 1'b0;
									walk_pop_q <= 1'b0;
									target_q   <= run_slot_q;
									state_q    <= S_RM_LOOK;
								end else begin
									state_q <= S_PICK;
								end
							end
						end
						default: begin
							// tick
							if (!run_valid_q || !req_q.cur_ready) begin
								state_q <= S_PICK;
							end else if (len_q == '0) begin
								state_q <= S_DONE;
							end else if (run_is_idle) begin
								idx_q      <= '0;
								found_q    <= 1'b0;
								walk_pop_q <= 1'b1;
								state_q    <= S_RM_LOOK;
							end else begin
								state_q <= S_TK_HEAD;
							end
						end
					endcase
				end

				S_RES_RD: begin
					state_q <= S_RES_INS;
				end

				S_RES_INS: begin
					ins_prio_q <= prio_rdata;
					state_q    <= S_INS_START;
				end

				S_TK_HEAD: begin
					state_q <= S_TK_HPRIO;
				end

				S_TK_HPRIO: begin
					state_q <= S_TK_RPRIO;
				end

				S_TK_RPRIO: begin
					head_prio_q <= prio_rdata;
					state_q     <= S_TK_CMP;
				end

				S_TK_CMP: begin
					// if the head is at least as urgent, requeue the running task behind equals and take the head
					if (head_prio_q <= prio_rdata) begin
						ins_slot_q <= run_slot_q;
						ins_prio_q <= prio_rdata;
						then_pop_q <= 1'b1;
						state_q    <= S_INS_START;
					end else begin
						state_q <= S_DONE;
					end
				end

				S_INS_START: begin
					if (queue_full) begin
						// drop the insert
						if (then_pop_q) begin
							idx_q      <= '0;
							found_q    <= 1'b0;
							walk_pop_q <= 1'b1;
							state_q    <= S_RM_LOOK;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						idx_q   <= len_q;
						state_q <= S_INS_LOOK;
					end
				end

				S_INS_LOOK: begin
					if (idx_q == '0) begin
						len_q                <= len_q + CW'(1);
						queued_q[ins_slot_q] <= 1'b1;
						if (then_pop_q) begin
							found_q    <= 1'b0;
							walk_pop_q <= 1'b1;
							state_q    <= S_RM_LOOK;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						state_q <= S_INS_ORD;
					end
				end

				S_INS_ORD: begin
					entry_q <= order_rdata;
					state_q <= S_INS_CMP;
				end

				S_INS_CMP: begin
					if (prio_rdata > ins_prio_q) begin
						// entry moved back one place, keep walking toward the head
						idx_q   <= idx_dec;
						state_q <= S_INS_LOOK;
					end else begin
						len_q                <= len_q + CW'(1);
						queued_q[ins_slot_q] <= 1'b1;
						if (then_pop_q) begin
							idx_q      <= '0;
							found_q    <= 1'b0;
							walk_pop_q <= 1'b1;
							state_q    <= S_RM_LOOK;
						end else begin
							state_q <= S_DONE;
						end
					end
				end

				S_RM_LOOK: begin
					if (idx_q == len_q) begin
						if (found_q) begin
							len_q          <= len_q - CW'(1);
							queued_q[rm_q] <= 1'b0;
						end
						if (walk_pop_q) begin
							run_slot_q  <= rm_q;
							run_valid_q <= 1'b1;
							state_q     <= S_DONE;
						end else begin
							state_q <= S_PICK;
						end
					end else begin
						state_q <= S_RM_CHK;
					end
				end

				S_RM_CHK: begin
					if (!found_q && rm_match) begin
						found_q <= 1'b1;
						rm_q    <= order_rdata;
					end
					idx_q   <= idx_q + CW'(1);
					state_q <= S_RM_LOOK;
				end

				S_PICK: begin
					// queue head, else idle task, else nothing
					if (len_q != '0) begin
						idx_q      <= '0;
						found_q    <= 1'b0;
						walk_pop_q <= 1'b1;
						state_q    <= S_RM_LOOK;
					end else if (idle_valid_q) begin
						run_slot_q  <= idle_slot_q;
						run_valid_q <= 1'b1;
						state_q     <= S_DONE;
					end else begin
						run_slot_q  <= '0;
						run_valid_q <= 1'b0;
						if (req_q.req_type == prqs_pkg::REQ_TICK) begin
							status_q <= prqs_pkg::STAT_ERR;
						end
						state_q <= S_DONE;
					end
				end

				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result view of the schedule
	assign idle              = (state_q == S_IDLE);
	assign done              = (state_q == S_DONE);
	assign res.current_task  = run_valid_q ? prqs_pkg::TASK_W'(run_slot_q) : '0;
	assign res.current_valid = run_valid_q;
	assign res.running_idle  = run_is_idle;
	assign res.status        = status_q;
	assign res.queue_count   = prqs_pkg::COUNT_W'(len_q);

endmodule

`default_nettype wire

// ===== tb/sv/priority_ready_queue_scheduler_unit_test.sv =====
// Tracks the scheduler state and the results it should produce, in request order
class sched_tracker;
	localparam int NSLOT = prqs_pkg::MAX_TASKS_DEF;

	logic [prqs_pkg::PRIO_W-1:0]  prio_of [NSLOT];
	bit                           live [NSLOT];
	bit [prqs_pkg::TASK_W-1:0]    order [NSLOT];
	bit [prqs_pkg::COUNT_W-1:0]   qlen = '0;
	bit [prqs_pkg::TASK_W-1:0]    run_slot = '0;
	bit                           run_valid = 1'b0;
	bit [prqs_pkg::TASK_W-1:0]    idle_slot = '0;
	bit                           idle_valid = 1'b0;
	bit [prqs_pkg::COUNT_W-1:0]   slots_used = '0;

	prqs_pkg::res_t pending [$];
	int             failures = 0;

	function new();
		for (int i = 0; i < NSLOT; i++) begin
			prio_of[i] = '0;
			live[i] = 1'b0;
			order[i] = '0;
		end
	endfunction

	// insert behind every queued task of equal or more urgent priority
	function void enqueue(bit [prqs_pkg::TASK_W-1:0] s);
		int pos;
		pos = 0;
		if (qlen >= NSLOT)
			return;
		while (pos < qlen && prio_of[order[pos]] <= prio_of[s])
			pos++;
		for (int i = qlen; i > pos; i--)
			order[i] = order[i-1];
		order[pos] = s;
		qlen++;
	endfunction

	function void drop_at(int pos);
		for (int i = pos; i + 1 < qlen; i++)
			order[i] = order[i+1];
		qlen--;
	endfunction

	function bit [prqs_pkg::TASK_W-1:0] take_head();
		bit [prqs_pkg::TASK_W-1:0] s;
		s = order[0];
		drop_at(0);
		return s;
	endfunction

	// select the queue head, else idle, else nothing
	function prqs_pkg::status_t choose_next();
		if (qlen > 0) begin
			run_slot = take_head();
			run_valid = 1'b1;
		end else if (idle_valid) begin
			run_slot = idle_slot;
			run_valid = 1'b1;
		end else begin
			run_slot = '0;
			run_valid = 1'b0;
			return prqs_pkg::STAT_ERR;
		end
		return prqs_pkg::STAT_OK;
	endfunction

	// advance the schedule by one accepted request and store the outcome
	function void note_request(prqs_pkg::req_t r);
		prqs_pkg::res_t            e;
		prqs_pkg::status_t         st;
		bit [prqs_pkg::TASK_W-1:0] s;
		bit                        refused;
		st = prqs_pkg::STAT_OK;
		case (r.req_type)
			prqs_pkg::REQ_CREATE: begin
				if (slots_used >= NSLOT) begin
					st = prqs_pkg::STAT_FULL;
				end else begin
					s = slots_used[prqs_pkg::TASK_W-1:0];
					slots_used++;
					prio_of[s] = r.priority_req;
					live[s] = 1'b1;
					if (r.create_idle) begin
						idle_slot = s;
						idle_valid = 1'b1;
					end
					if (!run_valid) begin
						run_slot = s;
						run_valid = 1'b1;
					end else if (!r.create_idle) begin
						enqueue(s);
					end
				end
			end
			prqs_pkg::REQ_RESUME: begin
				refused = !live[r.task_id] ||
					(idle_valid && idle_slot == r.task_id) ||
					(run_valid && run_slot == r.task_id);
				for (int i = 0; i < qlen; i++)
					if (order[i] == r.task_id)
						refused = 1'b1;
				if (refused)
					st = prqs_pkg::STAT_ERR;
				else
					enqueue(r.task_id);
			end
			prqs_pkg::REQ_END: begin
				if (!run_valid) begin
					st = prqs_pkg::STAT_ERR;
				end else begin
					live[run_slot] = 1'b0;
					for (int i = 0; i < qlen; i++)
						if (order[i] == run_slot) begin
							drop_at(i);
							break;
						end
					if (idle_valid && idle_slot == run_slot)
						idle_valid = 1'b0;
					void'(choose_next());
				end
			end
			default: begin
				if (!run_valid || !r.cur_ready) begin
					st = choose_next();
				end else if (qlen > 0) begin
					if (idle_valid && run_slot == idle_slot) begin
						run_slot = take_head();
					end else if (prio_of[order[0]] <= prio_of[run_slot]) begin
						enqueue(run_slot);
						run_slot = take_head();
					end
				end
			end
		endcase
		e.current_task = run_valid ? run_slot : '0;
		e.current_valid = run_valid;
		e.running_idle = run_valid && idle_valid && run_slot == idle_slot;
		e.status = st;
		e.queue_count = qlen;
		pending.push_back(e);
	endfunction

	// compare one delivered result against the oldest outcome
	function void check_result(prqs_pkg::res_t got);
		prqs_pkg::res_t e;
		if (pending.size() == 0) begin
			failures++;
			if (failures <= 10)
				$display("MISMATCH: result with nothing pending: task %0d valid %0b",
					got.current_task, got.current_valid);
			return;
		end
		e = pending.pop_front();
		if (got.current_task !== e.current_task || got.current_valid !== e.current_valid ||
				got.running_idle !== e.running_idle || got.status !== e.status ||
				got.queue_count !== e.queue_count) begin
			failures++;
			if (failures <= 10)
				$display("MISMATCH: exp task %0d valid %0b idle %0b status %0d count %0d, %s",
					e.current_task, e.current_valid, e.running_idle, e.status,
					e.queue_count, $sformatf("got task %0d valid %0b idle %0b status %0d count %0d",
					got.current_task, got.current_valid, got.running_idle, got.status,
					got.queue_count));
		end
	endfunction
endclass

module priority_ready_queue_scheduler_unit_test;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 60;
	localparam int PHASE_ITEMS = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	int src_gap_pct = 0;
	int sink_stall_pct = 0;
	int cycles = 0;

	sched_tracker tracker = new();

	priority_ready_queue_scheduler_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// stall the result side at random
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// note accepted requests first, then check delivered results
	always @(posedge clk) begin
		prqs_pkg::res_t got;
		if (s_tvalid && s_tready)
			tracker.note_request(prqs_pkg::req_t'{
				req_type: prqs_pkg::req_kind_t'(s_tuser),
				task_id: s_tdata[2:0], priority_req: s_tdata[10:3],
				create_idle: s_tdata[11], cur_ready: s_tdata[12]});
		if (m_tvalid && m_tready) begin
			got.current_task = m_tdata[2:0];
			got.current_valid = m_tdata[3];
			got.running_idle = m_tdata[4];
			got.status = prqs_pkg::status_t'(m_tdata[6:5]);
			got.queue_count = m_tdata[10:7];
			tracker.check_result(got);
		end
	end

	// end the run if it hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic prqs_pkg::req_t mk_req(prqs_pkg::req_kind_t kind, int id, int prio,
			bit idle, bit ready);
		prqs_pkg::req_t r;
		r.req_type = kind;
		r.task_id = id[prqs_pkg::TASK_W-1:0];
		r.priority_req = prio[prqs_pkg::PRIO_W-1:0];
		r.create_idle = idle;
		r.cur_ready = ready;
		return r;
	endfunction

	// mostly ticks and resumes; creates and ends stay rare since slots are never reused
	function automatic prqs_pkg::req_t random_request();
		prqs_pkg::req_t r;
		int unsigned    k;
		k = $urandom_range(999);
		if (k < 8)
			r.req_type = prqs_pkg::REQ_CREATE;
		else if (k < 11)
			r.req_type = prqs_pkg::REQ_END;
		else if (k < 450)
			r.req_type = prqs_pkg::REQ_RESUME;
		else
			r.req_type = prqs_pkg::REQ_TICK;
		r.task_id = prqs_pkg::TASK_W'($urandom_range(7));
		r.priority_req = prqs_pkg::PRIO_W'($urandom_range(255));
		r.create_idle = ($urandom_range(3) == 0);
		r.cur_ready = ($urandom_range(3) != 0);
		return r;
	endfunction

	// hold the request until accepted, with random gaps ahead of it
	task automatic push_request(prqs_pkg::req_t r);
		while ($urandom_range(99) < src_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= r.req_type;
		s_tdata <= {3'b000, r.cur_ready, r.create_idle, r.priority_req, r.task_id};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// nothing scheduled yet: tick, end and resume all fail
		push_request(mk_req(prqs_pkg::REQ_TICK, 0, 0, 1'b0, 1'b0));
		push_request(mk_req(prqs_pkg::REQ_END, 0, 0, 1'b0, 1'b1));
		push_request(mk_req(prqs_pkg::REQ_RESUME, 7, 0, 1'b0, 1'b1));
		// first task is idle and runs at once; next one is queued
		push_request(mk_req(prqs_pkg::REQ_CREATE, 0, 255, 1'b1, 1'b1));
		push_request(mk_req(prqs_pkg::REQ_CREATE, 0, 0, 1'b0, 1'b1));
		// idle yields to any queued task
		push_request(mk_req(prqs_pkg::REQ_TICK, 0, 0, 1'b0, 1'b1));
		// resume of idle and of the running task are refused
		push_request(mk_req(prqs_pkg::REQ_RESUME, 0, 0, 1'b0, 1'b1));
		push_request(mk_req(prqs_pkg::REQ_RESUME, 1, 0, 1'b0, 1'b1));
		// equal priority rotates on a ready tick
		push_request(mk_req(prqs_pkg::REQ_CREATE, 0, 0, 1'b0, 1'b1));
		push_request(mk_req(prqs_pkg::REQ_TICK, 0, 0, 1'b0, 1'b1));
		push_request(mk_req(prqs_pkg::REQ_RESUME, 1, 0, 1'b0, 1'b1));
		// blocked task leaves the schedule until resumed
		push_request(mk_req(prqs_pkg::REQ_TICK, 0, 0, 1'b0, 1'b0));
		push_request(mk_req(prqs_pkg::REQ_RESUME, 2, 0, 1'b0, 1'b1));
		// second idle task replaces the idle record
		push_request(mk_req(prqs_pkg::REQ_CREATE, 0, 128, 1'b1, 1'b1));
		// end tasks down to idle, then end idle itself
		push_request(mk_req(prqs_pkg::REQ_END, 0, 0, 1'b0, 1'b1));
		push_request(mk_req(prqs_pkg::REQ_END, 0, 0, 1'b0, 1'b1));
		push_request(mk_req(prqs_pkg::REQ_TICK, 0, 0, 1'b0, 1'b1));
		push_request(mk_req(prqs_pkg::REQ_END, 0, 0, 1'b0, 1'b1));
		push_request(mk_req(prqs_pkg::REQ_RESUME, 1, 0, 1'b0, 1'b1));
		push_request(mk_req(prqs_pkg::REQ_RESUME, 0, 0, 1'b0, 1'b1));

		// random traffic under four idling mixes
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_gap_pct = 64; sink_stall_pct = 0;  end
				2: begin src_gap_pct = 0;  sink_stall_pct = 64; end
				default: begin src_gap_pct = 31; sink_stall_pct = 31; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++)
				push_request(random_request());
		end
		s_tvalid <= 1'b0;

		// drain outstanding results, then watch for strays
		while (tracker.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.failures == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
